[hdl/dpa_pkg.sv]
`default_nettype none
package dpa_pkg;

    localparam int SUM_W   = 37;
    localparam int NUM_W   = SUM_W + 8;
    localparam int TOT_W   = NUM_W + 5;
    localparam int SCORE_W = 27;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 27'd134215680;

    typedef logic [1:0] cmd_t;
    typedef logic [SUM_W-1:0] sum_t;

    localparam cmd_t CMD_CLEAR  = 2'd0;
    localparam cmd_t CMD_SAMPLE = 2'd1;
    localparam cmd_t CMD_READ   = 2'd2;

    localparam logic [3:0] SHIFT_POS [16] = '{
        4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
        4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11};

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38, 8'hbf, 8'h40, 8'ha3, 8'h9e,
        8'h81, 8'hf3, 8'hd7, 8'hfb, 8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb, 8'h54, 8'h7b, 8'h94, 8'h32,
        8'ha6, 8'hc2, 8'h23, 8'h3d, 8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2, 8'h76, 8'h5b, 8'ha2, 8'h49,
        8'h6d, 8'h8b, 8'hd1, 8'h25, 8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92, 8'h6c, 8'h70, 8'h48, 8'h50,
        8'hfd, 8'hed, 8'hb9, 8'hda, 8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a, 8'hf7, 8'he4, 8'h58, 8'h05,
        8'hb8, 8'hb3, 8'h45, 8'h06, 8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b, 8'h3a, 8'h91, 8'h11, 8'h41,
        8'h4f, 8'h67, 8'hdc, 8'hea, 8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85, 8'he2, 8'hf9, 8'h37, 8'he8,
        8'h1c, 8'h75, 8'hdf, 8'h6e, 8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b, 8'hfc, 8'h56, 8'h3e, 8'h4b,
        8'hc6, 8'hd2, 8'h79, 8'h20, 8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31, 8'hb1, 8'h12, 8'h10, 8'h59,
        8'h27, 8'h80, 8'hec, 8'h5f, 8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef, 8'ha0, 8'he0, 8'h3b, 8'h4d,
        8'hae, 8'h2a, 8'hf5, 8'hb0, 8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26, 8'he1, 8'h69, 8'h14, 8'h63,
        8'h55, 8'h21, 8'h0c, 8'h7d};

    function automatic logic [7:0] ct_byte(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [3:0] pos);
        logic [127:0] ct;
        ct = {hi, lo};
        return ct[{pos, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

[hdl/dpa_in_if.sv]
`default_nettype none
interface dpa_in_if import dpa_pkg::*; ();
    logic              valid;
    logic              ready;
    cmd_t              command;
    logic [63:0]       ct_low;
    logic [63:0]       ct_high;
    logic [6:0]        sample_index;
    logic signed [15:0] sample_value;
    logic [7:0]        guess_select;

    modport source (output valid, command, ct_low, ct_high, sample_index, sample_value,
                    guess_select, input ready);
    modport sink (input valid, command, ct_low, ct_high, sample_index, sample_value,
                  guess_select, output ready);
endinterface
`default_nettype wire

[hdl/dpa_out_if.sv]
`default_nettype none
interface dpa_out_if import dpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] score;
    logic [7:0]         score_guess;
    logic [6:0]         score_sample;

    modport source (output valid, score, score_guess, score_sample, input ready);
    modport sink (input valid, score, score_guess, score_sample, output ready);
endinterface
`default_nettype wire

[hdl/dpa_ram.sv]
`default_nettype none
module dpa_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [W-1:0]             wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]                  rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hdl/dpa_div.sv]
`default_nettype none
module dpa_div import dpa_pkg::*; #(
    parameter int CNT_W = 20
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]        divisor,
    output logic                         done,
    output logic signed [NUM_W:0]        quotient
);
    localparam int SW = $clog2(NUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SW-1:0]     step_reg, step_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [CNT_W:0]    rem_sh;
    logic              ge;

    always_comb
    begin
        rem_sh    = {rem_reg, num_reg[NUM_W-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            num_next  = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = dividend[NUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? CNT_W'(rem_sh - {1'b0, dvs_reg}) : CNT_W'(rem_sh);
            num_next  = {num_reg[NUM_W-2:0], ge};
            step_next = SW'(step_reg + 1'b1);
            if (step_reg == SW'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});
endmodule
`default_nettype wire

[hdl/aes_last_round_dpa_accumulator_core.sv]
`default_nettype none
// Difference-of-means accumulator for a last-round AES-128 key byte attack. Sums
// live in two block RAMs of 256 x 2^max(1, ceil(log2(SAMPLES_PER_TRACE))) x 8
// entries, trace counts in two 2048-entry RAMs. After reset and after every clear
// item the block sweeps all RAMs, one address a cycle, and takes no item meanwhile.
// A sample item does one read-modify-write per guess and bit, pipelined over the
// registered RAM read; a sample item with an out-of-range index is dropped. A read
// item does, per bit, a RAM read and, when both classes hold traces, two serial
// divisions. A finished score waits in an output register while the next item is
// taken.
module aes_last_round_dpa_accumulator_core import dpa_pkg::*; #(
    parameter int SAMPLES_PER_TRACE = 128,
    parameter int MAX_TRACES        = 1048575
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_wdata,
    dpa_in_if.sink          req,
    dpa_out_if.source       rsp
);
    localparam int IDX_W  = (SAMPLES_PER_TRACE > 1) ? $clog2(SAMPLES_PER_TRACE) : 1;
    localparam int SUM_AW = 11 + IDX_W;
    localparam int SUM_D  = 1 << SUM_AW;
    localparam int CNT_W  = $clog2(MAX_TRACES + 1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CLEAR   = 4'd1;
    localparam logic [3:0] ST_ACC     = 4'd2;
    localparam logic [3:0] ST_ACC_END = 4'd3;
    localparam logic [3:0] ST_RD_ADDR = 4'd4;
    localparam logic [3:0] ST_RD_DATA = 4'd5;
    localparam logic [3:0] ST_DIV0    = 4'd6;
    localparam logic [3:0] ST_DIV1    = 4'd7;
    localparam logic [3:0] ST_RD_DONE = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [3:0]              tb_reg, tb_next;
    logic [7:0]              a_reg, a_next, b_reg, b_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [6:0]              sidx_reg, sidx_next;
    logic [7:0]              guess_reg, guess_next;
    logic signed [15:0]      samp_reg, samp_next;
    logic                    izero_reg, izero_next;
    logic [10:0]             cnt_reg, cnt_next;
    logic [SUM_AW-1:0]       clr_reg, clr_next;
    logic                    pv_reg, pv_next;
    logic                    pbit_reg, pbit_next;
    logic [SUM_AW-1:0]       paddr_reg, paddr_next;
    logic [2:0]              k_reg, k_next;
    logic signed [TOT_W-1:0] total_reg, total_next;
    sum_t                    s1_reg, s1_next;
    logic [CNT_W-1:0]        c1_reg, c1_next;
    logic signed [NUM_W:0]   q0_reg, q0_next;
    logic                    ov_reg, ov_next;
    logic [SCORE_W-1:0]      score_reg, score_next;
    logic [7:0]              og_reg, og_next;
    logic [6:0]              os_reg, os_next;

    logic [IDX_W+6:0]        idx_ext;
    logic                    in_range;
    logic [7:0]              sel_v;
    logic                    sel_bit;
    logic [SUM_AW-1:0]       sum_raddr, sum_waddr;
    logic [10:0]             cnt_raddr, cnt_waddr;
    logic                    we0, we1, cwe0, cwe1;
    sum_t                    rd0, rd1, upd_sum, wd0, wd1;
    logic [CNT_W-1:0]        rc0, rc1, upd_cnt, cwd0, cwd1;
    logic signed [SUM_W:0]   sum_wide;
    logic                    div_start, div_done;
    logic signed [NUM_W-1:0] div_num;
    logic [CNT_W-1:0]        div_dvs;
    logic signed [NUM_W:0]   div_q;
    logic signed [TOT_W-1:0] mag;
    logic                    accept;

    assign accept    = req.valid && req.ready;
    assign req.ready = state_reg == ST_IDLE;
    assign idx_ext   = {IDX_W'(0), req.sample_index};
    assign in_range  = 32'(req.sample_index) < SAMPLES_PER_TRACE;
    assign sel_v     = INV_SBOX[a_reg ^ cnt_reg[10:3]] ^ b_reg;
    assign sel_bit   = sel_v[~cnt_reg[2:0]];

    dpa_ram #(.W(SUM_W), .DEPTH(SUM_D)) u_sum0 (
        .clk(clk), .we(we0), .waddr(sum_waddr), .wdata(wd0), .raddr(sum_raddr), .rdata(rd0));
    dpa_ram #(.W(SUM_W), .DEPTH(SUM_D)) u_sum1 (
        .clk(clk), .we(we1), .waddr(sum_waddr), .wdata(wd1), .raddr(sum_raddr), .rdata(rd1));
    dpa_ram #(.W(CNT_W), .DEPTH(2048)) u_cnt0 (
        .clk(clk), .we(cwe0), .waddr(cnt_waddr), .wdata(cwd0), .raddr(cnt_raddr), .rdata(rc0));
    dpa_ram #(.W(CNT_W), .DEPTH(2048)) u_cnt1 (
        .clk(clk), .we(cwe1), .waddr(cnt_waddr), .wdata(cwd1), .raddr(cnt_raddr), .rdata(rc1));

    dpa_div #(.CNT_W(CNT_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
        .divisor(div_dvs), .done(div_done), .quotient(div_q));

    always_comb
    begin
        if (state_reg == ST_ACC)
        begin
            sum_raddr = {cnt_reg[10:3], idx_reg, cnt_reg[2:0]};
            cnt_raddr = cnt_reg;
        end
        else
        begin
            sum_raddr = {guess_reg, idx_reg, k_reg};
            cnt_raddr = {guess_reg, k_reg};
        end
        sum_wide = $signed({pbit_reg ? rd1[SUM_W-1] : rd0[SUM_W-1], pbit_reg ? rd1 : rd0})
                 + (SUM_W+1)'(samp_reg);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            upd_sum = {sum_wide[SUM_W], {(SUM_W-1){~sum_wide[SUM_W]}}};
        end
        else
        begin
            upd_sum = sum_wide[SUM_W-1:0];
        end
        upd_cnt = pbit_reg ? rc1 : rc0;
        if (32'(upd_cnt) < MAX_TRACES)
        begin
            upd_cnt = CNT_W'(upd_cnt + 1'b1);
        end
        if (state_reg == ST_CLEAR)
        begin
            we0 = 1'b1;
            we1 = 1'b1;
            cwe0 = 1'b1;
            cwe1 = 1'b1;
            sum_waddr = clr_reg;
            cnt_waddr = clr_reg[10:0];
            wd0 = '0;
            wd1 = '0;
            cwd0 = '0;
            cwd1 = '0;
        end
        else
        begin
            we0 = pv_reg && !pbit_reg;
            we1 = pv_reg && pbit_reg;
            cwe0 = we0 && izero_reg;
            cwe1 = we1 && izero_reg;
            sum_waddr = paddr_reg;
            cnt_waddr = {paddr_reg[SUM_AW-1 -: 8], paddr_reg[2:0]};
            wd0 = upd_sum;
            wd1 = upd_sum;
            cwd0 = upd_cnt;
            cwd1 = upd_cnt;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        tb_next    = cfg_we ? cfg_wdata : tb_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        idx_next   = idx_reg;
        sidx_next  = sidx_reg;
        guess_next = guess_reg;
        samp_next  = samp_reg;
        izero_next = izero_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        pv_next    = 1'b0;
        pbit_next  = sel_bit;
        paddr_next = {cnt_reg[10:3], idx_reg, cnt_reg[2:0]};
        k_next     = k_reg;
        total_next = total_reg;
        s1_next    = s1_reg;
        c1_next    = c1_reg;
        q0_next    = q0_reg;
        ov_next    = (ov_reg && rsp.ready) ? 1'b0 : ov_reg;
        score_next = score_reg;
        og_next    = og_reg;
        os_next    = os_reg;
        div_start  = 1'b0;
        div_num    = $signed({rd0, 8'h00});
        div_dvs    = rc0;
        mag        = total_reg[TOT_W-1] ? -total_reg : total_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    a_next     = ct_byte(req.ct_low, req.ct_high, tb_reg);
                    b_next     = ct_byte(req.ct_low, req.ct_high, SHIFT_POS[tb_reg]);
                    idx_next   = idx_ext[IDX_W-1:0];
                    sidx_next  = req.sample_index;
                    guess_next = req.guess_select;
                    samp_next  = req.sample_value;
                    izero_next = req.sample_index == 7'd0;
                    cnt_next   = '0;
                    clr_next   = '0;
                    k_next     = '0;
                    total_next = '0;
                    priority case (req.command)
                        CMD_CLEAR:  state_next = ST_CLEAR;
                        CMD_SAMPLE: state_next = in_range ? ST_ACC : ST_IDLE;
                        CMD_READ:   state_next = in_range ? ST_RD_ADDR : ST_RD_DONE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                clr_next = SUM_AW'(clr_reg + 1'b1);
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACC:
            begin
                pv_next  = 1'b1;
                cnt_next = 11'(cnt_reg + 1'b1);
                if (&cnt_reg)
                begin
                    state_next = ST_ACC_END;
                end
            end
            ST_ACC_END:
            begin
                state_next = ST_IDLE;
            end
            ST_RD_ADDR:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                s1_next = rd1;
                c1_next = rc1;
                if (rc0 == '0 || rc1 == '0)
                begin
                    k_next     = 3'(k_reg + 1'b1);
                    state_next = (&k_reg) ? ST_RD_DONE : ST_RD_ADDR;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV0;
                end
            end
            ST_DIV0:
            begin
                div_num = $signed({s1_reg, 8'h00});
                div_dvs = c1_reg;
                if (div_done)
                begin
                    q0_next    = div_q;
                    div_start  = 1'b1;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    total_next = total_reg + TOT_W'(q0_reg) - TOT_W'(div_q);
                    k_next     = 3'(k_reg + 1'b1);
                    state_next = (&k_reg) ? ST_RD_DONE : ST_RD_ADDR;
                end
            end
            ST_RD_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    score_next = (mag > TOT_W'(SCORE_MAX)) ? SCORE_MAX : mag[SCORE_W-1:0];
                    og_next    = guess_reg;
                    os_next    = sidx_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            tb_reg    <= '0;
            pv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            tb_reg    <= tb_next;
            pv_reg    <= pv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        idx_reg   <= idx_next;
        sidx_reg  <= sidx_next;
        guess_reg <= guess_next;
        samp_reg  <= samp_next;
        izero_reg <= izero_next;
        cnt_reg   <= cnt_next;
        pbit_reg  <= pbit_next;
        paddr_reg <= paddr_next;
        k_reg     <= k_next;
        total_reg <= total_next;
        s1_reg    <= s1_next;
        c1_reg    <= c1_next;
        q0_reg    <= q0_next;
        score_reg <= score_next;
        og_reg    <= og_next;
        os_reg    <= os_next;
    end

    assign rsp.valid        = ov_reg;
    assign rsp.score        = score_reg;
    assign rsp.score_guess  = og_reg;
    assign rsp.score_sample = os_reg;

`ifndef SYNTH
    a_one_class: assert property (@(posedge clk) disable iff (!rst_n)
        (we0 && we1) |-> state_reg == ST_CLEAR)
        else $error("both sum classes written outside clear");
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg) == ST_RD_DONE)
        else $error("result not from a read");
    a_pipe_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pv_reg)
        else $error("update pending while idle");
`endif
endmodule
`default_nettype wire
